FILE: sv/bwet_pkg.sv
package bwet_pkg;

  // Ring geometry
  localparam int DEPTH = 64;
  localparam int AW    = $clog2(DEPTH);
  localparam int NW    = $clog2(DEPTH + 1);

  // Register widths
  localparam int MIN_W = 7;
  localparam int CW    = (NW > MIN_W) ? NW : MIN_W;

  // Needed count: product / 256000 = (product >> 11) / 125
  localparam int PROD_W      = 40;
  localparam int DIV_SHIFT   = 11;
  localparam int DIV_ODD     = 125;
  localparam int QUOT_W      = PROD_W - DIV_SHIFT;
  localparam int QW          = $clog2(DIV_ODD * DEPTH);
  localparam int RECIP_SHIFT = 24;
  localparam int RECIP       = (2 ** RECIP_SHIFT + DIV_ODD - 1) / DIV_ODD;
  localparam int RW          = $clog2(RECIP + 1);

  // Lockout length
  localparam int MS_PER_S = 1000;
  localparam int SKIP_W   = 26;

  // Queue between front and back
  localparam int QDEPTH = 2;
  localparam int QAW    = $clog2(QDEPTH);
  localparam int QCW    = $clog2(QDEPTH + 1);

  // Register indexes
  localparam logic [1:0] CFG_WINDOW_MS    = 2'd0;
  localparam logic [1:0] CFG_SKIP_SECONDS = 2'd1;
  localparam logic [1:0] CFG_RATE_Q8      = 2'd2;
  localparam logic [1:0] CFG_MIN_COUNT    = 2'd3;

  typedef enum logic [1:0] {
    ST_LOCKING   = 2'd0,
    ST_CHECKING  = 2'd1,
    ST_TRIGGERED = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    F_IDLE,
    F_MUL,
    F_DIV,
    F_PUSH
  } front_state_e;

  typedef enum logic [1:0] {
    B_IDLE,
    B_READ,
    B_CMP,
    B_EMIT
  } back_state_e;

  typedef struct packed {
    logic [15:0]      window_ms;
    logic [15:0]      skip_seconds;
    logic [15:0]      rate_q8;
    logic [MIN_W-1:0] min_count;
  } cfg_t;

  typedef struct packed {
    logic [31:0]   time_ms;
    logic [NW-1:0] need;
  } job_t;

endpackage

FILE: sv/bwet_front.sv
module bwet_front (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  bwet_pkg::cfg_t        cfg_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [31:0]           time_ms_i,
  input  logic [7:0]            frame_rate_i,
  output logic                  job_valid_o,
  input  logic                  job_ready_i,
  output bwet_pkg::job_t        job_o
);

  bwet_pkg::front_state_e state_q, state_d;

  logic [31:0]                          time_q;
  logic [23:0]                          p1_q;
  logic [bwet_pkg::PROD_W-1:0]          p2_q;
  logic                                 big_q;
  logic [bwet_pkg::NW-1:0]              est_q;

  logic [bwet_pkg::QUOT_W-1:0]          quot;
  logic                                 big;
  logic [bwet_pkg::QW+bwet_pkg::RW-1:0] recip_prod;
  logic [bwet_pkg::CW-1:0]              need_w;

  // Sequence one request through multiply, divide and queue push
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bwet_pkg::F_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    in_ready_o  = 1'b0;
    job_valid_o = 1'b0;
    case (state_q)
      bwet_pkg::F_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) state_d = bwet_pkg::F_MUL;
      end
      bwet_pkg::F_MUL: state_d = bwet_pkg::F_DIV;
      bwet_pkg::F_DIV: state_d = bwet_pkg::F_PUSH;
      bwet_pkg::F_PUSH: begin
        job_valid_o = 1'b1;
        if (job_ready_i) state_d = bwet_pkg::F_IDLE;
      end
      default: state_d = bwet_pkg::F_IDLE;
    endcase
  end

  // Divide by 256000: shift out 2^11, then multiply by reciprocal of 125
  assign quot       = p2_q[bwet_pkg::PROD_W-1:bwet_pkg::DIV_SHIFT];
  assign big        = quot >= bwet_pkg::QUOT_W'(bwet_pkg::DIV_ODD * bwet_pkg::DEPTH);
  assign recip_prod = (bwet_pkg::QW + bwet_pkg::RW)'(quot[bwet_pkg::QW-1:0]) *
                      (bwet_pkg::QW + bwet_pkg::RW)'(bwet_pkg::RECIP);

  // Datapath registers, one stage per state before the push
  always_ff @(posedge clk_i) begin
    case (state_q)
      bwet_pkg::F_IDLE: begin
        if (in_valid_i) begin
          time_q <= time_ms_i;
          p1_q   <= 24'(frame_rate_i) * 24'(cfg_i.window_ms);
        end
      end
      bwet_pkg::F_MUL: begin
        p2_q <= bwet_pkg::PROD_W'(p1_q) * bwet_pkg::PROD_W'(cfg_i.rate_q8);
      end
      bwet_pkg::F_DIV: begin
        big_q <= big;
        est_q <= recip_prod[bwet_pkg::RECIP_SHIFT +: bwet_pkg::NW];
      end
      default: ;
    endcase
  end

  // Raise to the minimum, then saturate to the ring depth
  always_comb begin
    need_w = big_q ? bwet_pkg::CW'(bwet_pkg::DEPTH) : bwet_pkg::CW'(est_q);
    if (need_w < bwet_pkg::CW'(cfg_i.min_count)) need_w = bwet_pkg::CW'(cfg_i.min_count);
    if (need_w > bwet_pkg::CW'(bwet_pkg::DEPTH)) need_w = bwet_pkg::CW'(bwet_pkg::DEPTH);
  end

  assign job_o.time_ms = time_q;
  assign job_o.need    = need_w[bwet_pkg::NW-1:0];

endmodule

FILE: sv/bwet_fifo.sv
module bwet_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           wr_valid_i,
  output logic           wr_ready_o,
  input  bwet_pkg::job_t wr_data_i,
  output logic           rd_valid_o,
  input  logic           rd_ready_i,
  output bwet_pkg::job_t rd_data_o
);

  bwet_pkg::job_t               slot_q [bwet_pkg::QDEPTH];
  logic [bwet_pkg::QAW-1:0]     wr_ptr_q, rd_ptr_q;
  logic [bwet_pkg::QCW-1:0]     fill_q;
  logic                         push, pop;

  assign wr_ready_o = fill_q != bwet_pkg::QCW'(bwet_pkg::QDEPTH);
  assign rd_valid_o = fill_q != '0;
  assign push       = wr_valid_i && wr_ready_o;
  assign pop        = rd_valid_o && rd_ready_i;
  assign rd_data_o  = slot_q[rd_ptr_q];

  // Advance pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == bwet_pkg::QAW'(bwet_pkg::QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == bwet_pkg::QAW'(bwet_pkg::QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push && !pop) fill_q <= fill_q + 1'b1;
      else if (pop && !push) fill_q <= fill_q - 1'b1;
    end
  end

  // Hold queued requests
  always_ff @(posedge clk_i) begin
    if (push) slot_q[wr_ptr_q] <= wr_data_i;
  end

endmodule

FILE: sv/bwet_back.sv
module bwet_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  bwet_pkg::cfg_t cfg_i,
  input  logic           job_valid_i,
  output logic           job_ready_o,
  input  bwet_pkg::job_t job_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output logic [1:0]     status_o
);

  bwet_pkg::back_state_e state_q, state_d;

  logic [31:0]                 stamp_mem [bwet_pkg::DEPTH];
  logic [bwet_pkg::AW-1:0]     head_q;
  logic [bwet_pkg::NW-1:0]     count_q;
  logic [31:0]                 lock_q;
  logic [31:0]                 now_q;
  logic [bwet_pkg::AW-1:0]     oldest_q;
  logic [31:0]                 rd_q;
  logic [bwet_pkg::SKIP_W-1:0] skip_ms_q;
  bwet_pkg::status_e           status_q;
  logic [1:0]                  out_status_q;
  logic                        out_valid_q;

  logic [bwet_pkg::AW-1:0]     head_inc;
  logic [bwet_pkg::NW-1:0]     count_inc;
  logic [bwet_pkg::NW:0]       oldest_sum;
  logic [bwet_pkg::NW:0]       oldest_w;
  logic                        take;
  logic                        locked;
  logic                        hit;
  logic [32:0]                 deadline;
  logic [31:0]                 deadline_sat;
  logic                        out_free;

  // Push bookkeeping and oldest slot after the push
  assign head_inc   = (head_q == bwet_pkg::AW'(bwet_pkg::DEPTH - 1)) ? '0 : head_q + 1'b1;
  assign count_inc  = (count_q == bwet_pkg::NW'(bwet_pkg::DEPTH)) ? count_q : count_q + 1'b1;
  assign oldest_sum = (bwet_pkg::NW + 1)'(head_inc) + (bwet_pkg::NW + 1)'(bwet_pkg::DEPTH) -
                      (bwet_pkg::NW + 1)'(count_inc);
  assign oldest_w   = (oldest_sum >= (bwet_pkg::NW + 1)'(bwet_pkg::DEPTH)) ?
                      oldest_sum - (bwet_pkg::NW + 1)'(bwet_pkg::DEPTH) : oldest_sum;

  assign take     = (state_q == bwet_pkg::B_IDLE) && job_valid_i;
  assign locked   = job_i.time_ms < lock_q;
  assign hit      = (now_q - rd_q) <= {16'b0, cfg_i.window_ms};
  assign deadline = {1'b0, now_q} + 33'(skip_ms_q);
  assign deadline_sat = deadline[32] ? '1 : deadline[31:0];
  assign out_free = !out_valid_q || out_ready_i;

  assign job_ready_o = state_q == bwet_pkg::B_IDLE;
  assign out_valid_o = out_valid_q;
  assign status_o    = out_status_q;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bwet_pkg::B_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state: read the oldest stamp only when the event is not locked out and the ring is full enough
  always_comb begin
    state_d = state_q;
    case (state_q)
      bwet_pkg::B_IDLE: begin
        if (job_valid_i) begin
          if (!locked && count_inc >= job_i.need) state_d = bwet_pkg::B_READ;
          else state_d = bwet_pkg::B_EMIT;
        end
      end
      bwet_pkg::B_READ: state_d = bwet_pkg::B_CMP;
      bwet_pkg::B_CMP:  state_d = bwet_pkg::B_EMIT;
      bwet_pkg::B_EMIT: begin
        if (out_free) state_d = bwet_pkg::B_IDLE;
      end
      default: state_d = bwet_pkg::B_IDLE;
    endcase
  end

  // Ring pointers, lockout deadline and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q      <= '0;
      count_q     <= '0;
      lock_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (take && !locked) begin
        head_q  <= head_inc;
        count_q <= count_inc;
      end
      if (state_q == bwet_pkg::B_CMP) begin
        if (hit) begin
          lock_q  <= deadline_sat;
          count_q <= '0;
        end else begin
          count_q <= count_q - 1'b1;
        end
      end
      if (state_q == bwet_pkg::B_EMIT && out_free) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  // Payload of the request in flight
  always_ff @(posedge clk_i) begin
    if (take) begin
      now_q     <= job_i.time_ms;
      oldest_q  <= oldest_w[bwet_pkg::AW-1:0];
      skip_ms_q <= bwet_pkg::SKIP_W'(cfg_i.skip_seconds) * bwet_pkg::SKIP_W'(bwet_pkg::MS_PER_S);
      status_q  <= locked ? bwet_pkg::ST_LOCKING : bwet_pkg::ST_CHECKING;
    end
    if (state_q == bwet_pkg::B_CMP) begin
      status_q <= hit ? bwet_pkg::ST_TRIGGERED : bwet_pkg::ST_CHECKING;
    end
    if (state_q == bwet_pkg::B_EMIT && out_free) begin
      out_status_q <= status_q;
    end
  end

  // Stamp ring: write newest, registered read of oldest
  always_ff @(posedge clk_i) begin
    if (take && !locked) stamp_mem[head_q] <= job_i.time_ms;
    rd_q <= stamp_mem[oldest_q];
  end

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= bwet_pkg::NW'(bwet_pkg::DEPTH))
    else $error("ring count above depth");

  a_read_then_cmp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == bwet_pkg::B_READ |=> state_q == bwet_pkg::B_CMP)
    else $error("ring read not followed by compare");

  a_lock_only_cmp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != bwet_pkg::B_CMP |=> $stable(lock_q))
    else $error("lockout deadline moved outside compare");

  a_trigger_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == bwet_pkg::B_CMP && hit) |=> count_q == '0)
    else $error("ring not emptied on trigger");
`endif

endmodule

FILE: sv/burst_window_event_trigger_unit.sv
// An accepted event passes the front sequencer (multiply, divide, push) and the queue,
// then goes straight to emit when it is locked or the ring is short, or through read,
// compare and emit when the oldest stamp is read back.
// The front multiply/divide sequencer and the back's write, read, compare and emit steps
// on the stamp ring each finish one event before they take the next.
// Reset: asynchronous, active low; clears the ring pointers, the lockout deadline and
// loads register defaults (window 1000 ms, skip 10 s, rate 1.0, minimum 3).
module burst_window_event_trigger_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [31:0] time_ms_i,
  input  logic [7:0]  frame_rate_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  status_o
);

  bwet_pkg::cfg_t cfg_q;
  bwet_pkg::job_t front_job, back_job;
  logic           front_valid, front_ready;
  logic           back_valid, back_ready;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.window_ms    <= 16'd1000;
      cfg_q.skip_seconds <= 16'd10;
      cfg_q.rate_q8      <= 16'd256;
      cfg_q.min_count    <= bwet_pkg::MIN_W'(3);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        bwet_pkg::CFG_WINDOW_MS:    cfg_q.window_ms    <= cfg_data_i;
        bwet_pkg::CFG_SKIP_SECONDS: cfg_q.skip_seconds <= cfg_data_i;
        bwet_pkg::CFG_RATE_Q8:      cfg_q.rate_q8      <= cfg_data_i;
        bwet_pkg::CFG_MIN_COUNT:    cfg_q.min_count    <= cfg_data_i[bwet_pkg::MIN_W-1:0];
        default: ;
      endcase
    end
  end

  bwet_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .time_ms_i    (time_ms_i),
    .frame_rate_i (frame_rate_i),
    .job_valid_o  (front_valid),
    .job_ready_i  (front_ready),
    .job_o        (front_job)
  );

  bwet_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (front_valid),
    .wr_ready_o (front_ready),
    .wr_data_i  (front_job),
    .rd_valid_o (back_valid),
    .rd_ready_i (back_ready),
    .rd_data_o  (back_job)
  );

  bwet_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .job_valid_i (back_valid),
    .job_ready_o (back_ready),
    .job_i       (back_job),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_o    (status_o)
  );

endmodule
